### hw/rtl/text_console_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// Text console writer - assertion macros
// Clocked concurrent assertions; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("text console writer: assertion failed");

// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("text console writer: assertion failed");

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Operation codes, character codes, defaults and the controller state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] ATTR_RESET = 8'd15;
    localparam logic [7:0] CH_BLANK   = 8'd32;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;

    typedef enum logic [1:0] {
        KIND_PUT     = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_RECOLOR = 2'd2,
        KIND_READ    = 2'd3
    } tcw_kind_t;

    typedef enum logic [2:0] {
        ST_INIT,     // power-up sweep, blanks with reset attribute
        ST_IDLE,
        ST_FILL,     // blank fill, current attribute
        ST_MOVE,     // scroll copy, one row up
        ST_RECOLOR,  // attribute rewrite
        ST_DONE      // hand result to output register
    } tcw_state_t;

endpackage

### hw/rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 text-mode console engine: cell store in one dual-port RAM, cursor,
// put character / clear / recolor / read operations.
// ----------------------------------------------------------------------------
// Full-screen work: clear blanks all CELLS cells and recolor rewrites every
//   attribute; a put that scrolls copies CELLS-COLUMNS cells one row up, then
//   blanks the last row.
// Throughput: one item at a time; the next transfer is taken in the cycle after
//   the result is loaded. Full-screen work runs one cell per cycle on the RAM.
// Reset: synchronous, active low; a clearing pass blanks every cell of the RAM
//   in the reset attribute before the first input transfer is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: text attribute
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_char_code,
    input  logic [3:0]  s_new_foreground,
    input  logic [3:0]  s_new_background,
    input  logic [10:0] s_cell_index,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic [6:0]  m_cursor_column,
    output logic [4:0]  m_cursor_row
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);      // RAM address
    localparam int PW    = $clog2(CELLS + 1);  // sweep pointer, reaches CELLS
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [PW-1:0] PTR_LAST = PW'(CELLS - 1);
    localparam logic [PW-1:0] PTR_END  = PW'(CELLS);
    localparam logic [PW-1:0] PTR_COLS = PW'(COLUMNS);
    localparam logic [PW-1:0] PTR_LROW = PW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    // ------------------------------------------------------------------
    // Cell store: {attribute, character}, one write and one read port,
    // registered read data.
    // ------------------------------------------------------------------
    logic [15:0]   cell_mem [CELLS];
    logic [15:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    tcw_state_t    state_reg, state_next;
    logic [PW-1:0] ptr_reg, ptr_next;          // sweep pointer (read side)
    logic          pend_reg, pend_next;        // a read is in flight for write-back
    logic [AW-1:0] dst_reg, dst_next;          // write-back address of that read
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] line_reg, line_next;
    logic [7:0]    attr_reg;                   // text attribute register
    logic [7:0]    recolor_attr_reg, recolor_attr_next;
    logic          is_read_reg, is_read_next;
    logic          in_range_reg, in_range_next;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_cell_char_reg, m_cell_char_next;
    logic [7:0]    m_cell_attr_reg, m_cell_attr_next;
    logic [6:0]    m_cursor_column_reg, m_cursor_column_next;
    logic [4:0]    m_cursor_row_reg, m_cursor_row_next;

    // Cursor position as a linear cell number
    logic [31:0]   cur_lin;
    logic [31:0]   idx_w;
    logic [31:0]   col_w;
    logic [31:0]   line_w;
    logic [PW-1:0] ptr_up;                     // pointer one row back, for scroll
    logic [15:0]   blank_cur;
    logic          lf_req;
    logic          load;

    assign cur_lin   = 32'(line_reg) * COLUMNS + 32'(col_reg);
    assign idx_w     = 32'(s_cell_index);
    assign col_w     = 32'(col_reg);
    assign line_w    = 32'(line_reg);
    assign ptr_up    = ptr_reg - PTR_COLS;
    assign blank_cur = {attr_reg, CH_BLANK};

    // Configuration write: accepted any cycle; read by puts and by blank fills
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_we) begin
            attr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            col_reg     <= '0;
            line_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            col_reg     <= col_next;
            line_reg    <= line_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        dst_reg             <= dst_next;
        recolor_attr_reg    <= recolor_attr_next;
        is_read_reg         <= is_read_next;
        in_range_reg        <= in_range_next;
        m_cell_char_reg     <= m_cell_char_next;
        m_cell_attr_reg     <= m_cell_attr_next;
        m_cursor_column_reg <= m_cursor_column_next;
        m_cursor_row_reg    <= m_cursor_row_next;
    end

    // ------------------------------------------------------------------
    // Controller: next state, RAM port control, cursor update
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        pend_next         = pend_reg;
        dst_next          = dst_reg;
        col_next          = col_reg;
        line_next         = line_reg;
        recolor_attr_next = recolor_attr_reg;
        is_read_next      = is_read_reg;
        in_range_next     = in_range_reg;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;
        rd_en             = 1'b0;
        rd_addr           = '0;
        s_ready           = 1'b0;
        lf_req            = 1'b0;
        load              = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                wr_data  = {ATTR_RESET, CH_BLANK};
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == PTR_LAST) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    is_read_next      = (tcw_kind_t'(s_kind) == KIND_READ);
                    in_range_next     = (idx_w < CELLS);
                    recolor_attr_next = {s_new_background, s_new_foreground};
                    unique case (tcw_kind_t'(s_kind))
                        KIND_PUT: begin
                            if (s_char_code == CH_LF) begin
                                lf_req = 1'b1;
                            end else if (s_char_code == CH_CR) begin
                                col_next   = '0;
                                state_next = ST_DONE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = cur_lin[AW-1:0];
                                wr_data = {attr_reg, s_char_code};
                                if (col_reg == COL_LAST) begin
                                    // wrap: column 0, then line feed
                                    col_next = '0;
                                    lf_req   = 1'b1;
                                end else begin
                                    col_next   = col_reg + 1'b1;
                                    state_next = ST_DONE;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            ptr_next   = '0;
                            state_next = ST_FILL;
                        end
                        KIND_RECOLOR: begin
                            ptr_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_RECOLOR;
                        end
                        KIND_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_w[AW-1:0];
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                    if (lf_req) begin
                        if (line_reg == ROW_LAST) begin
                            // scroll: copy rows 1..ROWS-1 up, then blank last row
                            ptr_next   = PTR_COLS;
                            pend_next  = 1'b0;
                            state_next = ST_MOVE;
                        end else begin
                            line_next  = line_reg + 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_FILL: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                wr_data  = blank_cur;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == PTR_LAST) begin
                    state_next = ST_DONE;
                end
            end

            ST_MOVE, ST_RECOLOR: begin
                // write back the cell read last cycle
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = (state_reg == ST_MOVE) ? rd_data_reg
                                                     : {recolor_attr_reg, rd_data_reg[7:0]};
                end
                if (ptr_reg != PTR_END) begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = (state_reg == ST_MOVE) ? ptr_up[AW-1:0] : ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (state_reg == ST_MOVE) begin
                        ptr_next   = PTR_LROW;
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next         = m_valid_reg && !m_ready;
        m_cell_char_next     = m_cell_char_reg;
        m_cell_attr_next     = m_cell_attr_reg;
        m_cursor_column_next = m_cursor_column_reg;
        m_cursor_row_next    = m_cursor_row_reg;
        if (load) begin
            m_valid_next         = 1'b1;
            m_cell_char_next     = (is_read_reg && in_range_reg) ? rd_data_reg[7:0]  : 8'd0;
            m_cell_attr_next     = (is_read_reg && in_range_reg) ? rd_data_reg[15:8] : 8'd0;
            m_cursor_column_next = col_w[6:0];
            m_cursor_row_next    = line_w[4:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_char     = m_cell_char_reg;
    assign m_cell_attr     = m_cell_attr_reg;
    assign m_cursor_column = m_cursor_column_reg;
    assign m_cursor_row    = m_cursor_row_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TCW_ASSERT(a_one_at_a_time, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `TCW_ASSERT(a_col_range, aclk, aresetn, col_w < COLUMNS)
    `TCW_ASSERT(a_row_range, aclk, aresetn, line_w < ROWS)
    `TCW_ASSERT(a_move_order, aclk, aresetn,
        (state_reg == ST_MOVE && pend_reg) |-> (32'(dst_reg) + COLUMNS < 32'(ptr_reg)))
    `TCW_ASSERT(a_result_from_done, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))

endmodule

### tb/sv/tb_text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put / clear / recolor / read operations into the console engine and
// checks every result against a shadow copy of the 80x25 screen and cursor.
// A short directed part covers reset contents, character extremes, return,
// line feed, out-of-range reads, clear and recolor. Random text sessions with
// long lines (wrap) and many line feeds (scroll) follow, each under its own
// text attribute. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS_DEF * ROWS_DEF;

    // One result transfer as the block reports it.
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
    } cell_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        cfg_we           = 1'b0;
    logic [7:0]  cfg_wdata        = 8'd0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind           = 2'd0;
    logic [7:0]  s_char_code      = 8'd0;
    logic [3:0]  s_new_foreground = 4'd0;
    logic [3:0]  s_new_background = 4'd0;
    logic [10:0] s_cell_index     = 11'd0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_cell_char;
    logic [7:0]  m_cell_attr;
    logic [6:0]  m_cursor_column;
    logic [4:0]  m_cursor_row;

    always #5 aclk = ~aclk;

    text_console_writer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_char_code      (s_char_code),
        .s_new_foreground (s_new_foreground),
        .s_new_background (s_new_background),
        .s_cell_index     (s_cell_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_char      (m_cell_char),
        .m_cell_attr      (m_cell_attr),
        .m_cursor_column  (m_cursor_column),
        .m_cursor_row     (m_cursor_row)
    );

    // ------------------------------------------------------------------------
    // Shadow screen: what the console should hold right now
    // ------------------------------------------------------------------------
    logic [7:0]   shadow_char [CELLS];
    logic [7:0]   shadow_attr [CELLS];
    int unsigned  cur_col  = 0;
    int unsigned  cur_row  = 0;
    logic [7:0]   cur_attr = ATTR_RESET;

    cell_result_t pending_results [$];   // results owed by the block, oldest first

    int unsigned  error_count  = 0;
    int unsigned  items_sent   = 0;
    int unsigned  results_seen = 0;
    int unsigned  n_puts = 0, n_reads = 0, n_clears = 0, n_recolors = 0;
    int unsigned  n_scrolls = 0, n_wraps = 0, n_oob_reads = 0;

    // sender pacing: items left in the current burst
    int unsigned  burst_left = 0;

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            shadow_char[i] = CH_BLANK;
            shadow_attr[i] = ATTR_RESET;
        end
    end

    // Row advance; on the last row the screen moves up and a blank row enters.
    function automatic void advance_row();
        if (cur_row + 1 < ROWS_DEF) begin
            cur_row++;
        end else begin
            for (int i = COLUMNS_DEF; i < CELLS; i++) begin
                shadow_char[i - COLUMNS_DEF] = shadow_char[i];
                shadow_attr[i - COLUMNS_DEF] = shadow_attr[i];
            end
            for (int i = CELLS - COLUMNS_DEF; i < CELLS; i++) begin
                shadow_char[i] = CH_BLANK;
                shadow_attr[i] = cur_attr;
            end
            n_scrolls++;
        end
    endfunction

    // Applies one operation to the shadow screen and returns the result it owes.
    function automatic cell_result_t console_apply(tcw_kind_t kind, logic [7:0] ch,
                                                   logic [3:0] fg, logic [3:0] bg,
                                                   logic [10:0] idx);
        cell_result_t r;
        r = '0;
        case (kind)
            KIND_PUT: begin
                n_puts++;
                if (ch == CH_LF) begin
                    advance_row();
                end else if (ch == CH_CR) begin
                    cur_col = 0;
                end else begin
                    shadow_char[cur_row * COLUMNS_DEF + cur_col] = ch;
                    shadow_attr[cur_row * COLUMNS_DEF + cur_col] = cur_attr;
                    cur_col++;
                    // column wrap: back to 0 and an implied line feed
                    if (cur_col >= COLUMNS_DEF) begin
                        cur_col = 0;
                        n_wraps++;
                        advance_row();
                    end
                end
            end
            KIND_CLEAR: begin
                n_clears++;
                for (int i = 0; i < CELLS; i++) begin
                    shadow_char[i] = CH_BLANK;
                    shadow_attr[i] = cur_attr;
                end
            end
            KIND_RECOLOR: begin
                n_recolors++;
                for (int i = 0; i < CELLS; i++)
                    shadow_attr[i] = {bg, fg};
            end
            default: begin
                n_reads++;
                // out-of-range index reads back zero
                if (idx < CELLS) begin
                    r.ch   = shadow_char[idx];
                    r.attr = shadow_attr[idx];
                end else begin
                    n_oob_reads++;
                end
            end
        endcase
        r.col = cur_col[6:0];
        r.row = cur_row[4:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one input transfer, paced in bursts with random gaps.
    // Entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_op(input tcw_kind_t kind, input logic [7:0] ch,
                           input logic [3:0] fg, input logic [3:0] bg,
                           input logic [10:0] idx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_valid          = 1'b1;
        s_kind           = kind;
        s_char_code      = ch;
        s_new_foreground = fg;
        s_new_background = bg;
        s_cell_index     = idx;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(console_apply(kind, ch, fg, bg, idx));
        items_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_op(KIND_PUT, ch, 4'd0, 4'd0, 11'd0);
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send_op(KIND_READ, 8'd0, 4'd0, 4'd0, idx);
    endtask

    // Stops sending and waits for every owed result; the block is then idle.
    task automatic drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Attribute register write, only ever done with the block idle.
    task automatic set_text_attribute(input logic [7:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cur_attr  = value;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern -- long ready stretches, short ready
    // runs, and stalls.
    // ------------------------------------------------------------------------
    int unsigned rx_left = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready = 1'b1;
                    rx_left = $urandom_range(20, 60);
                end
                1: begin
                    m_ready = 1'b1;
                    rx_left = $urandom_range(1, 4);
                end
                default: begin
                    m_ready = 1'b0;
                    rx_left = $urandom_range(1, 8);
                end
            endcase
        end
        rx_left--;
    end

    // ------------------------------------------------------------------------
    // Result check: each result transfer against the oldest pending result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_result
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no operation pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_cell_char !== want.ch) begin
                    $error("cell_char mismatch: expected %0d, actual %0d", want.ch, m_cell_char);
                    error_count++;
                end
                if (m_cell_attr !== want.attr) begin
                    $error("cell_attr mismatch: expected %0d, actual %0d",
                           want.attr, m_cell_attr);
                    error_count++;
                end
                if (m_cursor_column !== want.col) begin
                    $error("cursor_column mismatch: expected %0d, actual %0d",
                           want.col, m_cursor_column);
                    error_count++;
                end
                if (m_cursor_row !== want.row) begin
                    $error("cursor_row mismatch: expected %0d, actual %0d",
                           want.row, m_cursor_row);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Screen after reset: blanks in the reset attribute; reads past the end
    // (including the top of the index range) return zero.
    task automatic test_reset_screen();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'h7FF);
    endtask

    // Character extremes, carriage return and a plain line feed.
    task automatic test_put_extremes();
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        read_cell(11'd1);
        read_cell(11'd2);
        put_char(CH_CR);
        read_cell(11'd0);
        put_char(CH_LF);
        put_char(8'h7E);
    endtask

    // Clear with the lowest attribute; the cursor must not move.
    task automatic test_clear_screen();
        set_text_attribute(8'h00);
        send_op(KIND_CLEAR, 8'd0, 4'd0, 4'd0, 11'd0);
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
    endtask

    // Recolor keeps the characters; highest and mixed colors.
    task automatic test_recolor_screen();
        logic [10:0] at;
        at = 11'(cur_row * COLUMNS_DEF + cur_col);
        put_char(8'h5A);
        send_op(KIND_RECOLOR, 8'd0, 4'hF, 4'hF, 11'd0);
        read_cell(at);
        send_op(KIND_RECOLOR, 8'd0, 4'hA, 4'h5, 11'd0);
        read_cell(at);
    endtask

    // Random text sessions: lines of random text, mostly short and sometimes
    // past the right margin, ended by return and/or line feeds so the cursor
    // reaches the bottom and the screen scrolls. Reads look at the screen along
    // the way; a share of fully random operations is mixed in.
    task automatic test_console_text(input logic [7:0] attr, input int unsigned n_items);
        int unsigned stop_at;
        int unsigned len;
        int unsigned extra_lf;
        logic [7:0]  ch;
        set_text_attribute(attr);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1: send_op(tcw_kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              11'($urandom_range(0, 2047)));
                2:    send_op(KIND_CLEAR, 8'd0, 4'd0, 4'd0, 11'd0);
                3:    send_op(KIND_RECOLOR, 8'd0, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 11'd0);
                default: begin
                    len = ($urandom_range(0, 99) < 12) ? $urandom_range(70, 85)
                                                       : $urandom_range(0, 4);
                    repeat (len) begin
                        ch = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(32, 126));
                        put_char(ch);
                        if ($urandom_range(0, 7) == 0) begin
                            if ($urandom_range(0, 1) == 0)
                                read_cell(11'(cur_row * COLUMNS_DEF + $urandom_range(0, 79)));
                            else
                                read_cell(11'($urandom_range(0, CELLS - 1)));
                        end
                    end
                    case ($urandom_range(0, 3))
                        0: begin
                            put_char(CH_CR);
                            put_char(CH_LF);
                        end
                        1: put_char(CH_LF);
                        2: put_char(CH_CR);
                        default: ;
                    endcase
                    extra_lf = $urandom_range(0, 3);
                    repeat (extra_lf) put_char(CH_LF);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : run
        int unsigned waited;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_screen();
        test_put_extremes();
        test_clear_screen();
        test_recolor_screen();

        test_console_text(8'hFF, 65);
        test_console_text(8'($urandom_range(0, 255)), 65);
        test_console_text(ATTR_RESET, 65);
        test_console_text(8'($urandom_range(0, 255)), 65);

        // let the last results come home; a scroll takes a full screen pass
        s_valid = 1'b0;
        waited  = 0;
        while (pending_results.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        $display("Console run: %0d operations, %0d results checked, %0d mismatches.",
                 items_sent, results_seen, error_count);
        $display("  %0d puts (%0d wraps, %0d scrolls), %0d clears, %0d recolors,",
                 n_puts, n_wraps, n_scrolls, n_clears, n_recolors);
        $display("  %0d reads (%0d out of range).", n_reads, n_oob_reads);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin : watchdog
        #(64'd40_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer_unit.sv
tb/sv/tb_text_console_writer_unit.sv
